// ===== hw/rtl/nmea_sentence_framer_checker_top_assert.svh =====
// Assertion macros shared by the framer RTL.
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_TOP_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSFC_ASSERT_NOW(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NSFC_ASSERT_NEXT(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== hw/rtl/nsfc_pkg.sv =====
`timescale 1ns / 1ps
package nsfc_pkg;

    typedef enum logic [2:0] {
        ST_GOOD     = 3'd0,
        ST_CSUM_BAD = 3'd1,
        ST_HDR_BAD  = 3'd2,
        ST_SHORT    = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // Configuration register indexes
    localparam logic REG_HEADER_TEXT   = 1'b0;
    localparam logic REG_HEADER_LENGTH = 1'b1;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] DIGIT_BASE  = 8'h30;
    localparam logic [7:0] ALPHA_ADJ   = 8'd7;
    localparam logic [7:0] DIGIT_MAX   = 8'd9;

    localparam int WINDOW      = 5;
    localparam int MIN_LEN     = 6;
    localparam int HDR_MAX     = 8;

    // Hex digit character to nibble, with 8-bit wrap as on the receiving side.
    function automatic logic [3:0] decode_digit(input logic [7:0] c);
        logic [7:0] d;
        d = c - DIGIT_BASE;
        if (d > DIGIT_MAX) begin
            d = d - ALPHA_ADJ;
        end
        return d[3:0];
    endfunction

endpackage

// ===== hw/rtl/nmea_sentence_framer_checker_top.sv =====
`timescale 1ns / 1ps
`include "nmea_sentence_framer_checker_top_assert.svh"
// NMEA 0183 sentence framer and checksum checker. Feed received UART bytes
// (s_kind = 0) or an end-of-packet timeout abort (s_kind = 1) one transfer
// at a time; the block accepts one transfer per cycle, and input stays
// ready while a result waits as long as m_ready is high in
// that cycle. Bytes are dropped until a '$'; the sentence then runs until
// CR LF and yields one result transfer: status, length, the XOR of bytes
// 1..n-6 and the value of the two hex digits before CR LF. A header mismatch
// outranks too short, which outranks a checksum error. After MAX_LEN bytes
// without CR LF an overflow result is sent. An abort returns to hunting with
// no result. Write header_text (index 0) and header_length (index 1) only
// while the block is idle.
module nmea_sentence_framer_checker_top #(
    parameter int MAX_LEN = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output nsfc_pkg::status_t   m_status,
    output logic [7:0]          m_sentence_length,
    output logic [7:0]          m_computed_checksum,
    output logic [7:0]          m_received_checksum
);
    import nsfc_pkg::*;

    localparam int CntW = $clog2(MAX_LEN + 1);
    localparam logic [CntW-1:0] MaxLenC = CntW'(MAX_LEN);
    localparam logic [CntW-1:0] MinLenC = CntW'(MIN_LEN);
    localparam logic [CntW-1:0] OneC    = CntW'(1);

    logic [63:0]     header_text_reg;
    logic [3:0]      header_length_reg;

    logic            collecting_reg, collecting_next;
    logic [CntW-1:0] byte_count_reg, byte_count_next;
    logic [7:0]      running_xor_reg, running_xor_next;
    logic [7:0]      recent_reg [WINDOW];
    logic [7:0]      recent_next [WINDOW];
    logic            header_bad_reg, header_bad_next;

    logic            m_valid_reg, m_valid_next;
    status_t         status_reg, status_next;
    logic [7:0]      length_reg, length_next;
    logic [7:0]      comp_reg, comp_next;
    logic [7:0]      recv_reg, recv_next;

    logic            accept;
    logic            emit;
    logic [3:0]      hdr_len;
    logic [CntW-1:0] pos;
    logic [CntW-1:0] n;
    logic            hbad;
    logic            tail_bad;
    logic            long_enough;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign hdr_len = (header_length_reg > 4'(HDR_MAX)) ? 4'(HDR_MAX) : header_length_reg;
    assign pos     = byte_count_reg;
    assign n       = pos + OneC;
    assign long_enough = (n >= MinLenC);

    // Header positions past the sentence end compare against zero bytes.
    always_comb begin
        tail_bad = 1'b0;
        for (int p = 0; p < HDR_MAX; p++) begin
            if ((CntW'(p) >= n) && (4'(p) < hdr_len) &&
                (header_text_reg[8*p +: 8] != 8'h00)) begin
                tail_bad = 1'b1;
            end
        end
    end

    always_comb begin
        collecting_next  = collecting_reg;
        byte_count_next  = byte_count_reg;
        running_xor_next = running_xor_reg;
        header_bad_next  = header_bad_reg;
        for (int i = 0; i < WINDOW; i++) begin
            recent_next[i] = recent_reg[i];
        end
        emit        = 1'b0;
        status_next = status_reg;
        length_next = length_reg;
        comp_next   = comp_reg;
        recv_next   = recv_reg;
        hbad        = header_bad_reg;

        if (accept) begin
            if (s_kind) begin
                collecting_next = 1'b0;
                byte_count_next = '0;
                header_bad_next = 1'b0;
            end else if (!collecting_reg) begin
                if (s_rx_byte == CHAR_DOLLAR) begin
                    collecting_next  = 1'b1;
                    byte_count_next  = OneC;
                    running_xor_next = 8'h00;
                    for (int i = 1; i < WINDOW; i++) begin
                        recent_next[i] = 8'h00;
                    end
                    recent_next[0]  = s_rx_byte;
                    header_bad_next = (hdr_len != 4'd0) &&
                                      (header_text_reg[7:0] != CHAR_DOLLAR);
                end
            end else begin
                if (pos >= MinLenC) begin
                    running_xor_next = running_xor_reg ^ recent_reg[WINDOW-1];
                end
                for (int i = 1; i < WINDOW; i++) begin
                    recent_next[i] = recent_reg[i-1];
                end
                recent_next[0] = s_rx_byte;
                if ((pos < CntW'(hdr_len)) &&
                    (header_text_reg[{pos[2:0], 3'b000} +: 8] != s_rx_byte)) begin
                    hbad = 1'b1;
                end
                header_bad_next = hbad;
                byte_count_next = n;

                if ((s_rx_byte == CHAR_LF) && (recent_reg[0] == CHAR_CR)) begin
                    emit        = 1'b1;
                    length_next = 8'(n);
                    if (long_enough) begin
                        comp_next = running_xor_next;
                        recv_next = {decode_digit(recent_next[3]),
                                     decode_digit(recent_next[2])};
                    end else begin
                        comp_next = 8'h00;
                        recv_next = 8'h00;
                    end
                    if (hbad || tail_bad) begin
                        status_next = ST_HDR_BAD;
                    end else if (!long_enough) begin
                        status_next = ST_SHORT;
                    end else if (comp_next != recv_next) begin
                        status_next = ST_CSUM_BAD;
                    end else begin
                        status_next = ST_GOOD;
                    end
                end else if (n >= MaxLenC) begin
                    emit        = 1'b1;
                    status_next = ST_OVERFLOW;
                    length_next = 8'(MAX_LEN);
                    comp_next   = 8'h00;
                    recv_next   = 8'h00;
                end

                // Drop back to hunting after any result.
                if (emit) begin
                    collecting_next = 1'b0;
                    byte_count_next = '0;
                    header_bad_next = 1'b0;
                end
            end
        end

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_text_reg   <= 64'h0;
            header_length_reg <= 4'h0;
            collecting_reg    <= 1'b0;
            byte_count_reg    <= '0;
            header_bad_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_HEADER_TEXT:   header_text_reg   <= cfg_wdata;
                    REG_HEADER_LENGTH: header_length_reg <= cfg_wdata[3:0];
                endcase
            end
            collecting_reg <= collecting_next;
            byte_count_reg <= byte_count_next;
            header_bad_reg <= header_bad_next;
            m_valid_reg    <= m_valid_next;
        end
        running_xor_reg <= running_xor_next;
        for (int i = 0; i < WINDOW; i++) begin
            recent_reg[i] <= recent_next[i];
        end
        status_reg <= status_next;
        length_reg <= length_next;
        comp_reg   <= comp_next;
        recv_reg   <= recv_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = status_reg;
    assign m_sentence_length   = length_reg;
    assign m_computed_checksum = comp_reg;
    assign m_received_checksum = recv_reg;

    `NSFC_ASSERT_NOW(a_hunt_count_zero, aclk, aresetn,
        !collecting_reg, byte_count_reg == '0, "byte count not cleared while hunting")
    `NSFC_ASSERT_NOW(a_collect_count_range, aclk, aresetn,
        collecting_reg, (byte_count_reg != '0) && (byte_count_reg < MaxLenC),
        "byte count out of range while collecting")
    `NSFC_ASSERT_NOW(a_overflow_fields, aclk, aresetn,
        m_valid_reg && (status_reg == ST_OVERFLOW),
        (length_reg == 8'(MAX_LEN)) && (comp_reg == 8'h00) && (recv_reg == 8'h00),
        "overflow result fields wrong")
    `NSFC_ASSERT_NOW(a_short_fields, aclk, aresetn,
        m_valid_reg && (status_reg == ST_SHORT),
        (length_reg < 8'(MIN_LEN)) && (comp_reg == 8'h00) && (recv_reg == 8'h00),
        "too-short result fields wrong")
    `NSFC_ASSERT_NEXT(a_abort_hunts, aclk, aresetn,
        accept && s_kind, !collecting_reg && !m_valid_next,
        "abort did not return to hunting")

endmodule
